[rtl/core/swm_pkg.sv]
// ---------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window median unit
// Holds the beat payloads, the window control and result structs, and the
// default sizing constants.
// ---------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int SPAN_W         = 6;
  localparam int MAX_WINDOW_DEF = 64;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SPAN_W-1:0]          span_t;

  localparam span_t SPAN_RESET = span_t'(2);

  // Payload of one input beat.
  typedef struct packed {
    sample_t sample;
    logic    last;
  } in_beat_t;

  // Payload of one result beat.
  typedef struct packed {
    sample_t median;
  } median_beat_t;

  // One window update, issued by the control logic.
  typedef struct packed {
    logic    fire;
    sample_t sample;
    logic    last;
  } step_t;

  // What the window reports for the sample at its input.
  typedef struct packed {
    logic    produce;
    sample_t median;
  } result_t;

endpackage

[rtl/core/swm_stream_if.sv]
// ---------------------------------------------------------------------------
// swm_stream_if: valid/ready channel
// Carries one payload of a configurable type per beat.
// ---------------------------------------------------------------------------
interface swm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[rtl/core/swm_window.sv]
// ---------------------------------------------------------------------------
// swm_window: sorted row of sample cells
// Each cell holds a sample and its age. A new sample is inserted by a
// parallel compare against every cell, the lower median is tapped from the
// merged row, and the oldest sample is squeezed out in the same cycle.
// ---------------------------------------------------------------------------
module swm_window #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  swm_pkg::step_t                    step,
  input  logic                              clear,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]   size,
  output swm_pkg::result_t                  result
);
  import swm_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  // Cell row state.
  sample_t              val   [MAX_WINDOW];
  logic [IDX_W-1:0]     age   [MAX_WINDOW];
  logic [CNT_W-1:0]     count;

  // Merged row after insertion, and row after removal.
  sample_t              val_a [MAX_WINDOW];
  logic [IDX_W-1:0]     age_a [MAX_WINDOW];
  sample_t              val_b [MAX_WINDOW];
  logic [IDX_W-1:0]     age_b [MAX_WINDOW];

  logic [MAX_WINDOW-1:0] le;
  logic [MAX_WINDOW-1:0] match;
  logic [MAX_WINDOW-1:0] at_or_above;
  logic                  full;
  logic [IDX_W-1:0]      med_idx;
  logic [IDX_W-1:0]      oldest_age;
  logic [CNT_W-1:0]      count_next;

  // Parallel compare: cells holding a value not above the new sample.
  // Since the row is sorted, this forms a thermometer code.
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      le[j] = (CNT_W'(j) < count) && (val[j] <= step.sample);
    end
  end

  // Merge the new sample in at the first cell above it; ages step up by one.
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (le[j]) begin
        val_a[j] = val[j];
        age_a[j] = age[j] + IDX_W'(1);
      end else if (j == 0) begin
        val_a[j] = step.sample;
        age_a[j] = '0;
      end else if (le[(j > 0) ? j - 1 : 0]) begin
        val_a[j] = step.sample;
        age_a[j] = '0;
      end else begin
        val_a[j] = val[(j > 0) ? j - 1 : 0];
        age_a[j] = age[(j > 0) ? j - 1 : 0] + IDX_W'(1);
      end
    end
  end

  // The window is full once the merged row holds size samples.
  assign full       = ((CNT_W+1)'(count) + (CNT_W+1)'(1)) == (CNT_W+1)'(size);
  assign oldest_age = IDX_W'(size - CNT_W'(1));
  assign med_idx    = IDX_W'(count >> 1);

  // Locate the oldest sample, then mark it and every cell above it.
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      match[j] = full && (CNT_W'(j) <= count) && (age_a[j] == oldest_age);
    end
  end

  assign at_or_above = ~(match - MAX_WINDOW'(1));

  // Cells at or above the removed one take their upper neighbor.
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (at_or_above[j] && (j < MAX_WINDOW - 1)) begin
        val_b[j] = val_a[(j < MAX_WINDOW - 1) ? j + 1 : j];
        age_b[j] = age_a[(j < MAX_WINDOW - 1) ? j + 1 : j];
      end else begin
        val_b[j] = val_a[j];
        age_b[j] = age_a[j];
      end
    end
  end

  // Lower median of the merged row.
  assign result.produce = full || step.last;
  assign result.median  = val_a[med_idx];

  // Fill count: a last beat or a new span empties the window.
  always_comb begin
    if (step.last) begin
      count_next = '0;
    end else if (full) begin
      count_next = count;
    end else begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clear) begin
      count <= '0;
    end else if (step.fire) begin
      count <= count_next;
    end
  end

  // Cell payloads carry no reset; cells at or above the count are ignored.
  always_ff @(posedge clk) begin
    if (step.fire) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        val[j] <= val_b[j];
        age[j] <= age_b[j];
      end
    end
  end

  // The count always stays below the window size.
  a_count_below_size: assert property (@(posedge clk) disable iff (rst)
    count < size)
    else $error("window count reached the window size");

  // A full window holds exactly one sample of the oldest age.
  a_single_oldest: assert property (@(posedge clk) disable iff (rst)
    full |-> $onehot(match))
    else $error("oldest sample not unique in a full window");

  // A full, non-final beat leaves the count unchanged.
  a_full_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (step.fire && full && !step.last && !clear) |=> (count == $past(count)))
    else $error("count moved on a full window");

  // A final beat empties the window.
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (step.fire && step.last) |=> (count == '0))
    else $error("window not emptied after the final beat");

endmodule

[rtl/core/sliding_window_median_unit.sv]
// ---------------------------------------------------------------------------
// sliding_window_median_unit: running lower-median filter
// A beat waits in the input register; its median goes to the output register.
// Throughput: 1 beat per cycle while the output is not stalled; one parallel
// compare over the cell row and one insert/remove shift of the row per cycle.
// Reset: window emptied, window_span set to 2, both channels empty.
// ---------------------------------------------------------------------------
module sliding_window_median_unit #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic         clk,
  input  logic         rst,
  swm_stream_if.sink   samples,
  swm_stream_if.source medians,
  swm_stream_if.sink   cfg
);
  import swm_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SZ_W  = (CNT_W > SPAN_W + 1) ? CNT_W : SPAN_W + 1;

  // Window size is span + 1, saturated at the row length.
  function automatic logic [CNT_W-1:0] span_to_size(input span_t span);
    logic [SZ_W-1:0] raw;
    raw = SZ_W'(span) + SZ_W'(1);
    if (raw > SZ_W'(MAX_WINDOW)) begin
      return CNT_W'(MAX_WINDOW);
    end
    return CNT_W'(raw);
  endfunction

  logic             cfg_write;
  logic [CNT_W-1:0] size;
  in_beat_t         in_q;
  logic             in_valid;
  median_beat_t     out_q;
  logic             out_valid;
  logic             advance;
  step_t            step;
  result_t          result;

  // Configuration is always taken; a write also empties the window.
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= span_to_size(SPAN_RESET);
    end else if (cfg_write) begin
      size <= span_to_size(cfg.data);
    end
  end

  // The held beat moves on when it makes no median or the output slot frees.
  assign advance = in_valid && (!result.produce || !out_valid || medians.ready);
  assign samples.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_q <= samples.data;
    end
  end

  // Window update request for the held beat.
  assign step.fire   = advance;
  assign step.sample = in_q.sample;
  assign step.last   = in_q.last;

  swm_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .clear  (cfg_write),
    .size   (size),
    .result (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.produce) begin
      out_valid <= 1'b1;
    end else if (medians.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.produce) begin
      out_q.median <= result.median;
    end
  end

  assign medians.valid = out_valid;
  assign medians.data  = out_q;

  // A beat that makes a median always lands in the output register.
  a_median_lands: assert property (@(posedge clk) disable iff (rst)
    (advance && result.produce) |=> out_valid)
    else $error("median lost on its way to the output register");

  // A full output slot that is not taken blocks a median-making beat.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !medians.ready && result.produce) |-> !advance)
    else $error("pending median overwritten");

  // Nothing is taken while the input register holds a stalled beat.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |-> !samples.ready)
    else $error("input accepted over a stalled beat");

endmodule

[test/tb_sliding_window_median_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sliding_window_median_unit: self-checking bench for the median unit
// Sends signed sample streams through the unit at several window spans.
// Its own sorted-window model predicts each lower median, and every result
// beat is checked in order against that prediction. Both channels idle in
// random bursts, and one long output stall makes the input back up.
// ---------------------------------------------------------------------------
module tb_sliding_window_median_unit;

  import swm_pkg::*;

  localparam int      WINDOW_CAP = MAX_WINDOW_DEF;
  localparam sample_t SAMPLE_MAX = sample_t'(32'h7fff_ffff);
  localparam sample_t SAMPLE_MIN = sample_t'(32'h8000_0000);
  localparam span_t   SPAN_TOP   = span_t'(63);
  localparam span_t   SPAN_ZERO  = span_t'(0);

  logic clk = 1'b0;
  logic rst = 1'b1;

  swm_stream_if #(.payload_t(in_beat_t))     samples_ch ();
  swm_stream_if #(.payload_t(median_beat_t)) medians_ch ();
  swm_stream_if #(.payload_t(span_t))        cfg_ch ();

  sliding_window_median_unit #(
    .MAX_WINDOW(WINDOW_CAP)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .medians(medians_ch),
    .cfg    (cfg_ch)
  );

  // Samples still to send, and medians still to arrive.
  in_beat_t sample_feed_q[$];
  sample_t  median_q[$];

  // Window model: current span, values in ascending order and in arrival order.
  span_t    span_cfg;
  sample_t  win_sorted[$];
  sample_t  win_age[$];

  int       err_count = 0;
  int       beats_accepted = 0;
  int       feed_gap = 0;
  int       drain_stall = 0;
  logic     idle_en = 1'b1;
  logic     sink_hold = 1'b0;
  logic     hold_arm = 1'b0;

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Window model: insert the new sample, emit the lower median once the
  // window is full (or when the stream ends early), then age out the oldest.
  function automatic void predict_median(in_beat_t beat);
    int      size;
    int      pos;
    sample_t oldest;
    size = int'(span_cfg) + 1;
    if (size > WINDOW_CAP) begin
      size = WINDOW_CAP;
    end
    if (win_age.size() >= size) begin
      win_sorted.delete();
      win_age.delete();
    end
    pos = 0;
    while (pos < win_sorted.size() && win_sorted[pos] <= beat.sample) begin
      pos++;
    end
    win_sorted.insert(pos, beat.sample);
    win_age.push_back(beat.sample);
    if (win_age.size() == size) begin
      median_q.push_back(win_sorted[(size - 1) / 2]);
      oldest = win_age.pop_front();
      pos = 0;
      while (win_sorted[pos] != oldest) begin
        pos++;
      end
      win_sorted.delete(pos);
    end else if (beat.last) begin
      median_q.push_back(win_sorted[(win_sorted.size() - 1) / 2]);
    end
    if (beat.last) begin
      win_sorted.delete();
      win_age.delete();
    end
  endfunction

  // Mix of extremes, a narrow band that forces duplicates, and full-range values.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0: begin
        return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      end
      1, 2: begin
        return sample_t'(int'($urandom_range(0, 8)) - 4);
      end
      default: begin
        return sample_t'($urandom);
      end
    endcase
  endfunction

  task automatic push_beat(sample_t value, logic is_last);
    in_beat_t beat;
    beat.sample = value;
    beat.last   = is_last;
    sample_feed_q.push_back(beat);
  endtask

  // Queue streams, some left without a final beat, until at least n samples are pending for this span.
  task automatic push_streams(span_t span, int n);
    int size;
    int count;
    int len;
    int kind;
    logic ends;
    size  = int'(span) + 1;
    count = 0;
    while (count < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        len  = $urandom_range(size, 3 * size + 2);
        ends = 1'b1;
      end else if (kind < 8) begin
        len  = $urandom_range(1, size);
        ends = 1'b1;
      end else begin
        len  = $urandom_range(1, 2 * size);
        ends = 1'b0;
      end
      for (int i = 0; i < len; i++) begin
        push_beat(pick_sample(), ends && (i == len - 1));
      end
      count += len;
    end
  endtask

  // Wait until every sample is sent and every median has come back, then
  // allow for samples that produce no median to clear the pipeline.
  task automatic wait_drained();
    while (sample_feed_q.size() != 0 || samples_ch.valid || median_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // One register write; the window empties with it.
  task automatic write_span(span_t value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    span_cfg = value;
    win_sorted.delete();
    win_age.delete();
  endtask

  task automatic run_phase(span_t span, int n, logic idling);
    wait_drained();
    write_span(span);
    idle_en = idling;
    push_streams(span, n);
  endtask

  // Sample driver: presents the next pending sample when the slot frees, apart from random idle gaps.
  always @(posedge clk) begin
    if (rst) begin
      samples_ch.valid <= 1'b0;
      samples_ch.data  <= '0;
      feed_gap = 0;
    end else begin
      if (samples_ch.valid && samples_ch.ready) begin
        predict_median(samples_ch.data);
        beats_accepted++;
      end
      if (!samples_ch.valid || samples_ch.ready) begin
        if (feed_gap == 0 && idle_en && $urandom_range(0, 7) == 0) begin
          feed_gap = $urandom_range(1, 12);
        end
        if (feed_gap > 0) begin
          feed_gap--;
          samples_ch.valid <= 1'b0;
        end else if (sample_feed_q.size() > 0) begin
          samples_ch.valid <= 1'b1;
          samples_ch.data  <= sample_feed_q.pop_front();
        end else begin
          samples_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Median monitor: checks each result beat and throttles ready.
  always @(posedge clk) begin
    sample_t want;
    logic    take;
    if (rst) begin
      medians_ch.ready <= 1'b0;
      drain_stall = 0;
    end else begin
      if (medians_ch.valid && medians_ch.ready) begin
        if (median_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected median beat: got %0d", medians_ch.data.median);
          end
        end else begin
          want = median_q.pop_front();
          if (medians_ch.data.median !== want) begin
            err_count++;
            if (err_count <= 10) begin
              $display("median mismatch: expected %0d, got %0d",
                       want, medians_ch.data.median);
            end
          end
        end
      end
      if (drain_stall == 0 && idle_en && $urandom_range(0, 7) == 0) begin
        drain_stall = $urandom_range(1, 12);
      end
      if (drain_stall > 0) begin
        drain_stall--;
        take = 1'b0;
      end else begin
        take = !sink_hold;
      end
      medians_ch.ready <= take;
    end
  end

  // Long output stall: once armed, let some beats through, then hold off
  // ready while the sender keeps offering samples.
  initial begin
    int mark;
    while (!hold_arm) @(posedge clk);
    mark = beats_accepted + 40;
    while (beats_accepted < mark) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (300) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Stimulus sequence.
  initial begin
    samples_ch.valid = 1'b0;
    samples_ch.data  = '0;
    medians_ch.ready = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    span_cfg         = SPAN_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset span: extremes through a full window, then short streams that
    // end before the window fills.
    push_beat(SAMPLE_MAX, 1'b0);
    push_beat(SAMPLE_MIN, 1'b0);
    push_beat(sample_t'(0), 1'b0);
    push_beat(sample_t'(-1), 1'b0);
    push_beat(sample_t'(1), 1'b1);
    push_beat(sample_t'(7), 1'b1);
    push_beat(SAMPLE_MAX, 1'b0);
    push_beat(SAMPLE_MIN, 1'b1);

    // Zero span: every sample is its own median.
    wait_drained();
    write_span(SPAN_ZERO);
    push_beat(SAMPLE_MAX, 1'b0);
    push_beat(SAMPLE_MIN, 1'b1);
    push_beat(sample_t'(5), 1'b0);

    // Widest span: a stream that ends long before the window fills.
    wait_drained();
    write_span(SPAN_TOP);
    for (int i = 0; i < 9; i++) begin
      push_beat(pick_sample(), 1'b0);
    end
    push_beat(SAMPLE_MIN, 1'b1);

    // Span of one, with a stream that ends exactly when the window fills.
    wait_drained();
    write_span(span_t'(1));
    push_beat(sample_t'(3), 1'b0);
    push_beat(sample_t'(-3), 1'b1);
    push_beat(sample_t'(4), 1'b0);

    // Random streams; the first phase also carries the long output stall.
    hold_arm = 1'b1;
    run_phase(SPAN_ZERO, 160, 1'b1);
    run_phase(SPAN_RESET, 150, 1'b1);
    run_phase(SPAN_TOP, 200, 1'b1);
    run_phase(span_t'($urandom_range(3, 20)), 150, 1'b0);
    run_phase(span_t'($urandom_range(0, 63)), 150, 1'b1);
    run_phase(span_t'(1), 120, 1'b1);
    run_phase(span_t'($urandom_range(0, 8)), 120, 1'b1);
    run_phase(SPAN_TOP, 180, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/swm_pkg.sv
rtl/core/swm_stream_if.sv
rtl/core/swm_window.sv
rtl/core/sliding_window_median_unit.sv
test/tb_sliding_window_median_unit.sv
